// File: rtl/bsrc_pkg.sv
package bsrc_pkg;

    localparam int MAX_BONDS      = 1024;
    localparam int ATOM_BITS      = 9;
    localparam int MAX_NEIGHBOURS = 16;
    localparam int BOND_AW        = $clog2(MAX_BONDS);
    localparam int CNT_W          = BOND_AW + 1;
    localparam int NB_W           = $clog2(MAX_NEIGHBOURS + 1);
    localparam int NB_IW          = $clog2(MAX_NEIGHBOURS);
    localparam int BOND_W         = 2 * ATOM_BITS;

    localparam logic [2:0] RING_NONE = 3'd0;
    localparam logic [2:0] RING_3    = 3'd3;
    localparam logic [2:0] RING_4    = 3'd4;
    localparam logic [2:0] RING_5    = 3'd5;

    typedef logic [ATOM_BITS-1:0] t_atom;
    typedef t_atom t_nlist [MAX_NEIGHBOURS];

    typedef enum logic [1:0] {
        K_CLEAR  = 2'd0,
        K_APPEND = 2'd1,
        K_QUERY  = 2'd2,
        K_NONE   = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_RANGE    = 2'd1,
        ST_FULL     = 2'd2,
        ST_OVERFLOW = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        RD_TGT = 2'd0,
        RD_P   = 2'd1,
        RD_Q   = 2'd2
    } t_rdsel;

    typedef enum logic [3:0] {
        S_IDLE, S_EXEC, S_TGT, S_G_RD, S_G_CHK, S_G_END, S_R3,
        S_P4_RD, S_P4_CHK, S_P5O_RD, S_P5O_LAT, S_P5I_RD, S_P5I_CHK, S_FIN
    } t_state;

    typedef struct packed {
        logic       load_in;
        logic       do_clear;
        logic       do_append;
        logic       rd_en;
        t_rdsel     rd_sel;
        logic       lat_tgt;
        logic       gather;
        logic       p_clr;
        logic       p_inc;
        logic       q_clr;
        logic       q_inc;
        logic       k_clr;
        logic       k_inc;
        logic       lat_p;
        logic       set_res;
        logic [2:0] res_ring;
        t_status    res_stat;
        logic       load_out;
    } t_cmd;

    typedef struct packed {
        t_kind kind;
        logic  idx_bad;
        logic  full;
        logic  over;
        logic  no_nb;
        logic  p_last;
        logic  q_last;
        logic  k_last;
        logic  hit3;
        logic  hit4;
        logic  hit5;
        logic  out_free;
    } t_sts;

endpackage

// File: rtl/bsrc_ram.sv
module bsrc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/bsrc_ctrl.sv
module bsrc_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  bsrc_pkg::t_sts  i_sts,
    output bsrc_pkg::t_cmd  o_cmd
);
    import bsrc_pkg::*;

    t_state r_state, n_state;
    t_cmd   c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        c          = '0;
        c.rd_sel   = RD_P;
        c.res_stat = ST_OK;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    c.load_in = 1'b1;
                    n_state   = S_EXEC;
                end
            end
            S_EXEC: begin
                c.set_res  = 1'b1;
                c.res_ring = RING_NONE;
                n_state    = S_FIN;
                unique case (i_sts.kind)
                    K_CLEAR: c.do_clear = 1'b1;
                    K_APPEND: begin
                        if (i_sts.full) begin
                            c.res_stat = ST_FULL;
                        end else begin
                            c.do_append = 1'b1;
                        end
                    end
                    K_QUERY: begin
                        if (i_sts.idx_bad) begin
                            c.res_stat = ST_RANGE;
                        end else begin
                            c.set_res = 1'b0;
                            c.rd_en   = 1'b1;
                            c.rd_sel  = RD_TGT;
                            n_state   = S_TGT;
                        end
                    end
                    K_NONE: ;
                    default: ;
                endcase
            end
            S_TGT: begin
                c.lat_tgt = 1'b1;
                c.p_clr   = 1'b1;
                n_state   = S_G_RD;
            end
            S_G_RD: begin
                c.rd_en = 1'b1;
                n_state = S_G_CHK;
            end
            S_G_CHK: begin
                c.gather = 1'b1;
                if (i_sts.p_last) begin
                    n_state = S_G_END;
                end else begin
                    c.p_inc = 1'b1;
                    n_state = S_G_RD;
                end
            end
            S_G_END: begin
                c.res_ring = RING_NONE;
                if (i_sts.over) begin
                    c.set_res  = 1'b1;
                    c.res_stat = ST_OVERFLOW;
                    n_state    = S_FIN;
                end else if (i_sts.no_nb) begin
                    c.set_res = 1'b1;
                    n_state   = S_FIN;
                end else begin
                    c.k_clr = 1'b1;
                    n_state = S_R3;
                end
            end
            S_R3: begin
                if (i_sts.hit3) begin
                    c.set_res  = 1'b1;
                    c.res_ring = RING_3;
                    n_state    = S_FIN;
                end else if (i_sts.k_last) begin
                    c.p_clr = 1'b1;
                    n_state = S_P4_RD;
                end else begin
                    c.k_inc = 1'b1;
                end
            end
            S_P4_RD: begin
                c.rd_en = 1'b1;
                n_state = S_P4_CHK;
            end
            S_P4_CHK: begin
                if (i_sts.hit4) begin
                    c.set_res  = 1'b1;
                    c.res_ring = RING_4;
                    n_state    = S_FIN;
                end else if (i_sts.p_last) begin
                    c.p_clr = 1'b1;
                    n_state = S_P5O_RD;
                end else begin
                    c.p_inc = 1'b1;
                    n_state = S_P4_RD;
                end
            end
            S_P5O_RD: begin
                c.rd_en = 1'b1;
                n_state = S_P5O_LAT;
            end
            S_P5O_LAT: begin
                c.lat_p = 1'b1;
                c.q_clr = 1'b1;
                n_state = S_P5I_RD;
            end
            S_P5I_RD: begin
                c.rd_en  = 1'b1;
                c.rd_sel = RD_Q;
                n_state  = S_P5I_CHK;
            end
            S_P5I_CHK: begin
                if (i_sts.hit5) begin
                    c.set_res  = 1'b1;
                    c.res_ring = RING_5;
                    n_state    = S_FIN;
                end else if (i_sts.q_last) begin
                    if (i_sts.p_last) begin
                        c.set_res  = 1'b1;
                        c.res_ring = RING_NONE;
                        n_state    = S_FIN;
                    end else begin
                        c.p_inc = 1'b1;
                        n_state = S_P5O_RD;
                    end
                end else begin
                    c.q_inc = 1'b1;
                    n_state = S_P5I_RD;
                end
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    c.load_out = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_cmd   = c;
    assign o_ready = (r_state == S_IDLE);

endmodule

// File: rtl/bsrc_dp.sv
module bsrc_dp (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [1:0]      i_kind,
    input  logic [8:0]      i_atom_first,
    input  logic [8:0]      i_atom_second,
    input  logic [9:0]      i_bond_index,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [2:0]      o_ring_size,
    output logic [1:0]      o_status,
    input  bsrc_pkg::t_cmd  i_cmd,
    output bsrc_pkg::t_sts  o_sts
);
    import bsrc_pkg::*;

    function automatic logic in_list(t_atom x, t_nlist l, logic [NB_W-1:0] n);
        logic h;
        h = 1'b0;
        for (int i = 0; i < MAX_NEIGHBOURS; i++) begin
            if ((NB_W'(i) < n) && (l[i] == x)) begin
                h = 1'b1;
            end
        end
        return h;
    endfunction

    t_kind               r_kind;
    t_atom               r_a_in, r_b_in;
    logic [9:0]          r_idx;
    logic [CNT_W-1:0]    r_count;
    t_atom               r_ta, r_tb;
    t_atom               r_pa, r_pb;
    logic                r_fpa, r_spa, r_fpb, r_spb;
    t_nlist              r_fn, r_sn;
    logic [NB_W-1:0]     r_nf, r_ns;
    logic                r_over;
    logic [CNT_W-1:0]    r_p, r_q;
    logic [NB_W-1:0]     r_k;
    logic [2:0]          r_ring;
    t_status             r_stat;
    logic                r_o_valid;
    logic [2:0]          r_o_ring;
    logic [1:0]          r_o_stat;

    logic [BOND_W-1:0]   rdata;
    logic [BOND_AW-1:0]  raddr;
    t_atom               c0, c1;
    logic                m0, m1, m2, m3, skip_p;
    logic [NB_W:0]       sum_f, sum_s;
    logic                f0, s0, f1, s1;
    logic                h5;

    always_comb begin
        unique case (i_cmd.rd_sel)
            RD_TGT:  raddr = BOND_AW'(r_idx);
            RD_Q:    raddr = r_q[BOND_AW-1:0];
            default: raddr = r_p[BOND_AW-1:0];
        endcase
    end

    bsrc_ram #(.WIDTH(BOND_W), .DEPTH(MAX_BONDS)) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.do_append),
        .i_waddr (r_count[BOND_AW-1:0]),
        .i_wdata ({r_a_in, r_b_in}),
        .i_re    (i_cmd.rd_en),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign c0     = rdata[BOND_W-1:ATOM_BITS];
    assign c1     = rdata[ATOM_BITS-1:0];
    assign skip_p = (32'(r_p) == 32'(r_idx));
    assign m0     = !skip_p && (c0 == r_ta);
    assign m1     = !skip_p && (c1 == r_ta);
    assign m2     = !skip_p && (c0 == r_tb);
    assign m3     = !skip_p && (c1 == r_tb);
    assign sum_f  = (NB_W+1)'(r_nf) + (NB_W+1)'(m0) + (NB_W+1)'(m1);
    assign sum_s  = (NB_W+1)'(r_ns) + (NB_W+1)'(m2) + (NB_W+1)'(m3);

    assign f0 = in_list(c0, r_fn, r_nf);
    assign s0 = in_list(c0, r_sn, r_ns);
    assign f1 = in_list(c1, r_fn, r_nf);
    assign s1 = in_list(c1, r_sn, r_ns);

    // shared atom pa/pb with q0/q1, far ends checked against both lists
    always_comb begin
        h5 = 1'b0;
        if (r_pa == c0) h5 = h5 | (r_fpb && s1) | (f1 && r_spb);
        if (r_pa == c1) h5 = h5 | (r_fpb && s0) | (f0 && r_spb);
        if (r_pb == c0) h5 = h5 | (r_fpa && s1) | (f1 && r_spa);
        if (r_pb == c1) h5 = h5 | (r_fpa && s0) | (f0 && r_spa);
        if (r_q == r_p) h5 = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cmd.do_clear) r_count <= '0;
            if (i_cmd.do_append) r_count <= r_count + 1'b1;
            if (i_cmd.load_out) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_kind <= t_kind'(i_kind);
            r_a_in <= i_atom_first[ATOM_BITS-1:0];
            r_b_in <= i_atom_second[ATOM_BITS-1:0];
            r_idx  <= i_bond_index;
        end
        if (i_cmd.lat_tgt) begin
            r_ta   <= c0;
            r_tb   <= c1;
            r_nf   <= '0;
            r_ns   <= '0;
            r_over <= 1'b0;
        end
        if (i_cmd.gather) begin
            for (int i = 0; i < MAX_NEIGHBOURS; i++) begin
                if (m0 && NB_W'(i) == r_nf) begin
                    r_fn[i] <= c1;
                end else if (m1 && NB_W'(i) == r_nf + NB_W'(m0)) begin
                    r_fn[i] <= c0;
                end
                if (m2 && NB_W'(i) == r_ns) begin
                    r_sn[i] <= c1;
                end else if (m3 && NB_W'(i) == r_ns + NB_W'(m2)) begin
                    r_sn[i] <= c0;
                end
            end
            if (32'(sum_f) > MAX_NEIGHBOURS || 32'(sum_s) > MAX_NEIGHBOURS) begin
                r_over <= 1'b1;
            end else begin
                r_nf <= sum_f[NB_W-1:0];
                r_ns <= sum_s[NB_W-1:0];
            end
        end
        if (i_cmd.p_clr) r_p <= '0;
        if (i_cmd.p_inc) r_p <= r_p + 1'b1;
        if (i_cmd.q_clr) r_q <= '0;
        if (i_cmd.q_inc) r_q <= r_q + 1'b1;
        if (i_cmd.k_clr) r_k <= '0;
        if (i_cmd.k_inc) r_k <= r_k + 1'b1;
        if (i_cmd.lat_p) begin
            r_pa  <= c0;
            r_pb  <= c1;
            r_fpa <= f0;
            r_spa <= s0;
            r_fpb <= f1;
            r_spb <= s1;
        end
        if (i_cmd.set_res) begin
            r_ring <= i_cmd.res_ring;
            r_stat <= i_cmd.res_stat;
        end
        if (i_cmd.load_out) begin
            r_o_ring <= r_ring;
            r_o_stat <= r_stat;
        end
    end

    assign o_sts.kind     = r_kind;
    assign o_sts.idx_bad  = (32'(r_idx) >= 32'(r_count));
    assign o_sts.full     = (32'(r_count) >= MAX_BONDS);
    assign o_sts.over     = r_over;
    assign o_sts.no_nb    = (r_nf == '0) || (r_ns == '0);
    assign o_sts.p_last   = (r_p + 1'b1 == r_count);
    assign o_sts.q_last   = (r_q + 1'b1 == r_count);
    assign o_sts.k_last   = (r_k + 1'b1 == r_ns);
    assign o_sts.hit3     = in_list(r_sn[r_k[NB_IW-1:0]], r_fn, r_nf);
    assign o_sts.hit4     = !skip_p && ((f0 && s1) || (f1 && s0));
    assign o_sts.hit5     = h5;
    assign o_sts.out_free = !r_o_valid || i_ready;

    assign o_valid     = r_o_valid;
    assign o_ring_size = r_o_ring;
    assign o_status    = r_o_stat;

endmodule

// File: rtl/bond_small_ring_classifier_core.sv
// Bond store with small-ring query. Each item clears the store, appends a bond,
// queries one stored bond or does nothing, and gives one result. Clear, append and
// rejected queries go from the execute state straight to the result. A query runs
// on one read port of the bond store: it gathers neighbours over the stored bonds,
// then runs the 3-ring test, the 4-ring scan and the 5-ring pair scan, ending at the
// first ring found. No clearing pass after reset.
module bond_small_ring_classifier_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [1:0] i_kind,
    input  logic [8:0] i_atom_first,
    input  logic [8:0] i_atom_second,
    input  logic [9:0] i_bond_index,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [2:0] o_ring_size,
    output logic [1:0] o_status
);
    import bsrc_pkg::*;

    t_cmd cmd;
    t_sts sts;

    bsrc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    bsrc_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_kind        (i_kind),
        .i_atom_first  (i_atom_first),
        .i_atom_second (i_atom_second),
        .i_bond_index  (i_bond_index),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_ring_size   (o_ring_size),
        .o_status      (o_status),
        .i_cmd         (cmd),
        .o_sts         (sts)
    );

endmodule

// File: dv/bond_small_ring_classifier_core_tb.sv
`timescale 1ns / 100ps

module bond_small_ring_classifier_core_tb;
    import bsrc_pkg::*;

    typedef struct {
        t_kind      kind;
        t_atom      a;
        t_atom      b;
        logic [9:0] idx;
        bit         typed;
        logic [2:0] ring;
        t_status    stat;
    } t_bond_op;

    typedef struct {
        logic [2:0] ring;
        t_status    stat;
    } t_ring_ans;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_ready;
    logic [1:0] i_kind = K_CLEAR;
    logic [8:0] i_atom_first = '0;
    logic [8:0] i_atom_second = '0;
    logic [9:0] i_bond_index = '0;
    logic       o_valid;
    logic       i_ready = 1'b0;
    logic [2:0] o_ring_size;
    logic [1:0] o_status;

    bond_small_ring_classifier_core uut (.*);

    always #5 i_clk = ~i_clk;

    // predictor state
    t_atom     pr_bonds [MAX_BONDS][2];
    int        pr_count = 0;
    t_atom     pr_fn [MAX_NEIGHBOURS];
    t_atom     pr_sn [MAX_NEIGHBOURS];
    bit        mark_f [1 << ATOM_BITS];
    bit        mark_s [1 << ATOM_BITS];

    t_bond_op  sent_q [$];
    t_ring_ans ring_q [$];
    int        errors = 0;
    int        n_items = 0;
    int        n_results = 0;
    int        n_rings [6];
    int        send_idle = 0;
    int        recv_idle = 0;
    int        hold_cycles = 0;

    task automatic report(input string what, input int got, input int want);
        errors++;
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    endtask

    function automatic bit pair_hit(input t_atom x, input t_atom y);
        return (mark_f[x] && mark_s[y]) || (mark_f[y] && mark_s[x]);
    endfunction

    function automatic logic [2:0] smallest_ring(input int tgt, input int ns);
        for (int k = 0; k < ns; k++)
            if (mark_f[pr_sn[k]]) return RING_3;
        for (int p = 0; p < pr_count; p++)
            if (p != tgt && pair_hit(pr_bonds[p][0], pr_bonds[p][1])) return RING_4;
        for (int p = 0; p < pr_count; p++)
            for (int q = 0; q < pr_count; q++)
                if (q != p)
                    for (int e = 0; e < 2; e++)
                        for (int f = 0; f < 2; f++)
                            if (pr_bonds[p][e] == pr_bonds[q][f] &&
                                pair_hit(pr_bonds[p][1-e], pr_bonds[q][1-f]))
                                return RING_5;
        return RING_NONE;
    endfunction

    function automatic t_ring_ans predict_ring(input t_bond_op op);
        t_ring_ans r;
        int        nf, ns, tgt;
        bit        over;
        t_atom     a, b, c0, c1;
        r.ring = RING_NONE;
        r.stat = ST_OK;
        nf = 0;
        ns = 0;
        over = 0;
        case (op.kind)
            K_CLEAR: pr_count = 0;
            K_APPEND: begin
                if (pr_count >= MAX_BONDS) begin
                    r.stat = ST_FULL;
                end else begin
                    pr_bonds[pr_count][0] = op.a;
                    pr_bonds[pr_count][1] = op.b;
                    pr_count++;
                end
            end
            K_QUERY: begin
                tgt = int'(op.idx);
                if (tgt >= pr_count) begin
                    r.stat = ST_RANGE;
                end else begin
                    a = pr_bonds[tgt][0];
                    b = pr_bonds[tgt][1];
                    for (int j = 0; j < pr_count && !over; j++) begin
                        if (j == tgt) continue;
                        c0 = pr_bonds[j][0];
                        c1 = pr_bonds[j][1];
                        if (c0 == a) begin
                            if (nf >= MAX_NEIGHBOURS) over = 1; else pr_fn[nf++] = c1;
                        end
                        if (c1 == a) begin
                            if (nf >= MAX_NEIGHBOURS) over = 1; else pr_fn[nf++] = c0;
                        end
                        if (c0 == b) begin
                            if (ns >= MAX_NEIGHBOURS) over = 1; else pr_sn[ns++] = c1;
                        end
                        if (c1 == b) begin
                            if (ns >= MAX_NEIGHBOURS) over = 1; else pr_sn[ns++] = c0;
                        end
                    end
                    if (over) begin
                        r.stat = ST_OVERFLOW;
                    end else if (nf != 0 && ns != 0) begin
                        for (int k = 0; k < nf; k++) mark_f[pr_fn[k]] = 1;
                        for (int k = 0; k < ns; k++) mark_s[pr_sn[k]] = 1;
                        r.ring = smallest_ring(tgt, ns);
                        for (int k = 0; k < nf; k++) mark_f[pr_fn[k]] = 0;
                        for (int k = 0; k < ns; k++) mark_s[pr_sn[k]] = 0;
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // accepted items feed the predictor, accepted results are checked
    always @(posedge i_clk) begin
        t_bond_op  op;
        t_ring_ans r;
        if (i_rst_n && i_valid && o_ready) begin
            op = sent_q.pop_front();
            r = predict_ring(op);
            if (op.typed) begin
                r.ring = op.ring;
                r.stat = op.stat;
            end
            ring_q.push_back(r);
        end
        if (i_rst_n && o_valid && i_ready) begin
            n_results++;
            if (ring_q.size() == 0) begin
                report("unexpected result", o_ring_size, -1);
            end else begin
                r = ring_q.pop_front();
                if (o_ring_size !== r.ring) report("ring_size", o_ring_size, r.ring);
                if (o_status !== r.stat) report("status", o_status, r.stat);
                if (r.ring <= 5) n_rings[r.ring]++;
            end
        end
    end

    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            i_ready = 1'b0;
            hold_cycles--;
        end else begin
            i_ready = ($urandom_range(99) >= recv_idle);
        end
    end

    task automatic send(input t_bond_op op);
        if ($urandom_range(99) < send_idle) begin
            @(negedge i_clk);
            i_valid = 1'b0;
            repeat ($urandom_range(3)) @(negedge i_clk);
        end
        @(negedge i_clk);
        sent_q.push_back(op);
        i_valid = 1'b1;
        i_kind = op.kind;
        i_atom_first = op.a;
        i_atom_second = op.b;
        i_bond_index = op.idx;
        n_items++;
        do @(posedge i_clk); while (!o_ready);
    endtask

    function automatic t_bond_op mk(input t_kind k, input int a, input int b, input int idx);
        t_bond_op op;
        op.kind = k;
        op.a = t_atom'(a);
        op.b = t_atom'(b);
        op.idx = 10'(idx);
        op.typed = 0;
        op.ring = RING_NONE;
        op.stat = ST_OK;
        return op;
    endfunction

    function automatic t_bond_op mkx(input t_kind k, input int a, input int b, input int idx,
                                     input logic [2:0] ring, input t_status stat);
        t_bond_op op;
        op = mk(k, a, b, idx);
        op.typed = 1;
        op.ring = ring;
        op.stat = stat;
        return op;
    endfunction

    task automatic drain();
        @(negedge i_clk);
        i_valid = 1'b0;
        wait (ring_q.size() == 0 && sent_q.size() == 0);
    endtask

    initial begin
        t_bond_op dir_tab [$];
        int       base, nb, nq;
        dir_tab = {
            mkx(K_QUERY, 0, 0, 0, RING_NONE, ST_RANGE),
            mkx(K_NONE, 511, 511, 1023, RING_NONE, ST_OK),
            mkx(K_APPEND, 0, 1, 0, RING_NONE, ST_OK),
            mk(K_APPEND, 1, 2, 0),
            mk(K_APPEND, 2, 0, 0),
            mkx(K_QUERY, 0, 0, 0, RING_3, ST_OK),
            mk(K_APPEND, 511, 511, 0),
            mkx(K_QUERY, 0, 0, 3, RING_NONE, ST_OK),
            mkx(K_QUERY, 0, 0, 1023, RING_NONE, ST_RANGE),
            mkx(K_CLEAR, 0, 0, 0, RING_NONE, ST_OK),
            mk(K_APPEND, 10, 11, 0),
            mk(K_APPEND, 11, 12, 0),
            mk(K_APPEND, 12, 13, 0),
            mk(K_APPEND, 13, 10, 0),
            mkx(K_QUERY, 0, 0, 0, RING_4, ST_OK),
            mk(K_CLEAR, 0, 0, 0),
            mk(K_APPEND, 20, 21, 0),
            mk(K_APPEND, 21, 22, 0),
            mk(K_APPEND, 22, 23, 0),
            mk(K_APPEND, 23, 24, 0),
            mk(K_APPEND, 24, 20, 0),
            mkx(K_QUERY, 0, 0, 2, RING_5, ST_OK),
            mk(K_QUERY, 0, 0, 4),
            mk(K_CLEAR, 0, 0, 0),
            mk(K_APPEND, 30, 31, 0)
        };
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_tab[i]) send(dir_tab[i]);
        send(mk(K_APPEND, 31, 32, 0));
        send(mkx(K_QUERY, 0, 0, 0, RING_NONE, ST_OK));
        drain();

        // neighbour overflow on each end
        send(mk(K_CLEAR, 0, 0, 0));
        send(mk(K_APPEND, 100, 200, 0));
        for (int k = 0; k < 17; k++) send(mk(K_APPEND, 100, 300 + k, 0));
        send(mkx(K_QUERY, 0, 0, 0, RING_NONE, ST_OVERFLOW));
        send(mk(K_CLEAR, 0, 0, 0));
        send(mk(K_APPEND, 100, 200, 0));
        for (int k = 0; k < 17; k++) send(mk(K_APPEND, 400 + k, 200, 0));
        send(mkx(K_QUERY, 0, 0, 0, RING_NONE, ST_OVERFLOW));

        // fill the store, the receiver holding off at the start
        send(mk(K_CLEAR, 0, 0, 0));
        hold_cycles = 400;
        for (int k = 0; k < MAX_BONDS; k++)
            send(mk(K_APPEND, $urandom_range(511), $urandom_range(511), 0));
        send(mkx(K_APPEND, 5, 6, 0, RING_NONE, ST_FULL));
        send(mk(K_CLEAR, 0, 0, 0));
        drain();

        for (int ph = 0; ph < 3; ph++) begin
            send_idle = (ph == 0) ? 34 : (ph == 1) ? 46 : 0;
            recv_idle = (ph == 0) ? 46 : (ph == 1) ? 34 : 0;
            for (int s = 0; s < 8; s++) begin
                send(mk(K_CLEAR, 0, 0, 0));
                base = $urandom_range(511 - 9);
                nb = $urandom_range(3, 12);
                nq = $urandom_range(3, 6);
                for (int k = 0; k < nb; k++) begin
                    if ($urandom_range(9) == 0)
                        send(mk(K_APPEND, $urandom_range(511), base + $urandom_range(9), 0));
                    else
                        send(mk(K_APPEND, base + $urandom_range(9), base + $urandom_range(9),
                                0));
                end
                for (int k = 0; k < nq; k++) begin
                    if ($urandom_range(7) == 0)
                        send(mk(K_QUERY, 0, 0, $urandom_range(1023)));
                    else if ($urandom_range(9) == 0)
                        send(mk(K_NONE, $urandom_range(511), $urandom_range(511),
                                $urandom_range(1023)));
                    else
                        send(mk(K_QUERY, 0, 0, $urandom_range(nb + 1)));
                end
            end
            drain();
        end

        repeat (50) @(posedge i_clk);
        $display("%0d items sent, %0d results: none %0d, ring3 %0d, ring4 %0d, ring5 %0d",
                 n_items, n_results, n_rings[0], n_rings[3], n_rings[4], n_rings[5]);
        $display("covered range, full store, overflow on both ends, stalls and hold-off");
        if (errors == 0)
            $display("bond_small_ring_classifier_core test passed");
        else
            $display("bond_small_ring_classifier_core test failed");
        $finish;
    end

    initial begin
        #20ms;
        $display("bond_small_ring_classifier_core test failed");
        $finish;
    end

endmodule
